>>> src/kcmt_pkg.sv
// ----------------------------------------------------------------------------
// kcmt_pkg
// Shared constants, codes and types of the key count min/max tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kcmt_pkg;

    localparam int MAX_KEYS   = 64;
    localparam int KEY_BITS   = 16;
    localparam int COUNT_BITS = 32;

    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int REC_W = IDX_W;
    localparam int N_W   = $clog2(MAX_KEYS + 1);
    localparam int CR_W  = COUNT_BITS + REC_W;

    localparam int S_TDATA_W = ((KEY_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = COUNT_BITS + 2 * KEY_BITS;
    localparam int M_TDATA_W = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_KEYS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    localparam logic OP_INC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_SWEEP,
        ST_SWEEP_END,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_PROMOTE,
        ACT_REMOVE
    } action_t;

    typedef struct packed {
        logic             accept;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             decide;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

>>> src/kcmt_ctrl.sv
// ----------------------------------------------------------------------------
// kcmt_ctrl
// Sequencer: accepts a transaction, runs the lookup sweep and the update
// sweep over the table, then hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcmt_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire kcmt_pkg::status_t status,
    output kcmt_pkg::cmd_t        cmd
);
    import kcmt_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cnt_next   = '0;
                state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.rd_addr  = cnt_reg;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
            end
            ST_SWEEP: begin
                cmd.rd_en = 1'b1;
            end
            ST_DONE: begin
                cmd.load_out = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_SCAN) && (cnt_reg == '0))
        else $error("accepted transaction did not start the lookup sweep");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |-> $past(state_reg) == ST_SCAN_END)
        else $error("decision taken before the lookup sweep finished");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !status.out_busy)
        else $error("result loaded over an unsent result");

endmodule

`default_nettype wire

>>> src/kcmt_datapath.sv
// ----------------------------------------------------------------------------
// kcmt_datapath
// Key table storage, lookup, update and min/max search, and the output
// register of the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcmt_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire kcmt_pkg::cmd_t                  cmd,
    output kcmt_pkg::status_t                    status,
    input  wire logic [kcmt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [kcmt_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [kcmt_pkg::M_TUSER_W-1:0]       m_tuser
);
    import kcmt_pkg::*;

    logic [KEY_BITS-1:0] key_mem [MAX_KEYS];
    logic [CR_W-1:0]     cr_mem  [MAX_KEYS];

    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [CR_W-1:0]       rd_cr_reg;
    logic                  pipe_vld_reg;
    logic [IDX_W-1:0]      pipe_idx_reg;
    logic                  sweep_reg;

    logic                  op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [MAX_KEYS-1:0]   valid_reg;

    logic                  hit_found_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [COUNT_BITS-1:0] hit_count_reg;
    logic [REC_W-1:0]      hit_rec_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic [N_W-1:0]        n_reg;

    action_t               act_reg, act_next;
    logic [IDX_W-1:0]      tgt_reg, tgt_next;
    logic [COUNT_BITS-1:0] tgt_count_reg, tgt_count_next;
    logic [REC_W-1:0]      tgt_rec_reg, tgt_rec_next;
    logic [COUNT_BITS-1:0] res_count_reg, res_count_next;
    logic                  res_drop_reg, res_drop_next;

    logic                  best_found_reg;
    logic [KEY_BITS-1:0]   max_key_reg, min_key_reg;
    logic [COUNT_BITS-1:0] max_cnt_reg, min_cnt_reg;
    logic [REC_W-1:0]      max_rec_reg, min_rec_reg;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TUSER_W-1:0]  m_tuser_reg;

    logic [COUNT_BITS-1:0] rd_count;
    logic [REC_W-1:0]      rd_rec;
    logic                  rd_valid;
    logic [COUNT_BITS-1:0] ent_count;
    logic [REC_W-1:0]      ent_rec;
    logic                  shift;
    logic [N_W-1:0]        n_less_one;

    assign rd_count   = rd_cr_reg[CR_W-1:REC_W];
    assign rd_rec     = rd_cr_reg[REC_W-1:0];
    assign rd_valid   = valid_reg[pipe_idx_reg];
    assign shift      = (act_reg == ACT_PROMOTE) || (act_reg == ACT_REMOVE);
    assign n_less_one = n_reg - 1'b1;

    // Decision on the scanned entry.
    always_comb begin
        act_next       = ACT_NONE;
        res_drop_next  = 1'b0;
        tgt_next       = hit_idx_reg;
        tgt_count_next = hit_count_reg;
        tgt_rec_next   = n_less_one[REC_W-1:0];
        res_count_next = '0;
        if (op_reg == OP_INC) begin
            if (hit_found_reg) begin
                res_count_next = hit_count_reg;
                if (hit_count_reg != COUNT_MAX) begin
                    act_next       = ACT_PROMOTE;
                    tgt_count_next = hit_count_reg + 1'b1;
                    res_count_next = tgt_count_next;
                end
            end else if (free_found_reg) begin
                act_next       = ACT_INSERT;
                tgt_next       = free_idx_reg;
                tgt_count_next = COUNT_ONE;
                tgt_rec_next   = n_reg[REC_W-1:0];
                res_count_next = COUNT_ONE;
            end else begin
                res_drop_next = 1'b1;
            end
        end else if (hit_found_reg) begin
            if (hit_count_reg <= COUNT_ONE) begin
                act_next = ACT_REMOVE;
            end else begin
                act_next       = ACT_PROMOTE;
                tgt_count_next = hit_count_reg - 1'b1;
                res_count_next = tgt_count_next;
            end
        end
    end

    // New count and rank of the entry coming out of the table in a sweep.
    always_comb begin
        ent_count = rd_count;
        ent_rec   = rd_rec;
        if ((pipe_idx_reg == tgt_reg) &&
            ((act_reg == ACT_INSERT) || (act_reg == ACT_PROMOTE))) begin
            ent_count = tgt_count_reg;
            ent_rec   = tgt_rec_reg;
        end else if (shift && (rd_rec > hit_rec_reg)) begin
            ent_rec = rd_rec - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_key_reg <= key_mem[cmd.rd_addr];
            rd_cr_reg  <= cr_mem[cmd.rd_addr];
        end
        if (cmd.decide && (act_next == ACT_INSERT)) begin
            key_mem[tgt_next] <= key_reg;
        end
        if (pipe_vld_reg && sweep_reg) begin
            cr_mem[pipe_idx_reg] <= {ent_count, ent_rec};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_vld_reg <= 1'b0;
            sweep_reg    <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pipe_vld_reg <= cmd.rd_en;
            if (cmd.accept) begin
                sweep_reg <= 1'b0;
            end else if (cmd.decide) begin
                sweep_reg <= 1'b1;
            end
            if (cmd.decide && (act_next == ACT_INSERT)) begin
                valid_reg[tgt_next] <= 1'b1;
            end else if (cmd.decide && (act_next == ACT_REMOVE)) begin
                valid_reg[tgt_next] <= 1'b0;
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pipe_idx_reg <= cmd.rd_addr;
        if (cmd.accept) begin
            op_reg         <= s_tuser;
            key_reg        <= s_tdata[KEY_BITS-1:0];
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            n_reg          <= '0;
        end else if (pipe_vld_reg && !sweep_reg) begin
            if (rd_valid) begin
                n_reg <= n_reg + 1'b1;
                if (!hit_found_reg && (rd_key_reg == key_reg)) begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= pipe_idx_reg;
                    hit_count_reg <= rd_count;
                    hit_rec_reg   <= rd_rec;
                end
            end else if (!free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= pipe_idx_reg;
            end
        end
        if (cmd.decide) begin
            act_reg        <= act_next;
            tgt_reg        <= tgt_next;
            tgt_count_reg  <= tgt_count_next;
            tgt_rec_reg    <= tgt_rec_next;
            res_count_reg  <= res_count_next;
            res_drop_reg   <= res_drop_next;
            best_found_reg <= 1'b0;
        end else if (pipe_vld_reg && sweep_reg && rd_valid) begin
            best_found_reg <= 1'b1;
            if (!best_found_reg || (ent_count > max_cnt_reg) ||
                ((ent_count == max_cnt_reg) && (ent_rec > max_rec_reg))) begin
                max_key_reg <= rd_key_reg;
                max_cnt_reg <= ent_count;
                max_rec_reg <= ent_rec;
            end
            if (!best_found_reg || (ent_count < min_cnt_reg) ||
                ((ent_count == min_cnt_reg) && (ent_rec > min_rec_reg))) begin
                min_key_reg <= rd_key_reg;
                min_cnt_reg <= ent_count;
                min_rec_reg <= ent_rec;
            end
        end
        if (cmd.load_out) begin
            m_tdata_reg <= M_TDATA_W'({
                best_found_reg ? min_key_reg : {KEY_BITS{1'b0}},
                best_found_reg ? max_key_reg : {KEY_BITS{1'b0}},
                res_count_reg});
            m_tuser_reg <= {res_drop_reg, !best_found_reg};
        end
    end

    assign status.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign m_tuser         = m_tuser_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide && (act_next == ACT_INSERT) |=> valid_reg[tgt_reg])
        else $error("inserted key did not take its slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (m_tuser_reg[0] == (valid_reg == '0)))
        else $error("empty flag disagrees with the table");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[1] |-> m_tdata_reg[COUNT_BITS-1:0] == '0)
        else $error("dropped transaction reports a nonzero count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[0] |->
            m_tdata_reg[M_DATA_BITS-1:COUNT_BITS] == '0)
        else $error("empty table reports a max or min key");

endmodule

`default_nettype wire

>>> src/key_count_minmax_tracker.sv
// ----------------------------------------------------------------------------
// key_count_minmax_tracker
// Table of up to 64 keys with counts; reports the updated count and the
// keys with the largest and smallest count after every request.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one request per transaction: s_tuser is the
// request type (0 increments, 1 decrements) and s_tdata carries the key.
// Every request gives exactly one result transaction on the output
// channel: m_tdata holds the key's new count, the max key and the min key,
// and m_tuser holds the empty and dropped flags.
// Between acceptance of a request and its loaded result, one
// sweep over all table entries finds the key, its rank and a free slot,
// and a second sweep writes the updated counts and ranks back while it
// searches for the max and min keys. Both sweeps are bound by the single
// read port of the table memories, one entry per cycle.
// The next request is accepted in the cycle after the result is loaded,
// and a new request can be processed while a result waits to be taken.
// If the receiver stalls with a result already waiting, the block holds
// the next finished result until the output register frees up.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_count_minmax_tracker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: key.
    input  wire logic [kcmt_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: req_type.
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Fields from bit 0: key_count, max_key, min_key.
    output logic [kcmt_pkg::M_TDATA_W-1:0]       m_tdata,
    // Fields from bit 0: is_empty, dropped.
    output logic [kcmt_pkg::M_TUSER_W-1:0]       m_tuser
);
    import kcmt_pkg::*;

    cmd_t    cmd;
    status_t status;

    kcmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kcmt_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
